>>> hw/rtl/pfpe_pkg.sv
package pfpe_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;

    localparam logic [1:0] KIND_PLOT      = 2'd0;
    localparam logic [1:0] KIND_READ_PIX  = 2'd1;
    localparam logic [1:0] KIND_FILL      = 2'd2;
    localparam logic [1:0] KIND_READ_BYTE = 2'd3;

    localparam logic [2:0] PLOT_CLEAR     = 3'd0;
    localparam logic [2:0] PLOT_CLEAR_ALT = 3'd2;
    localparam logic [2:0] PLOT_INVERT    = 3'd4;

    localparam logic [2:0] FILL_CLEAR = 3'd0;
    localparam logic [2:0] FILL_SET   = 3'd1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

endpackage

>>> hw/rtl/page_framebuffer_pixel_engine_unit.sv
// Page-organized monochrome frame store, 1024 bytes, one byte per eight
// stacked pixels. A request is taken when i_start is high and o_busy is low;
// its result appears for exactly one cycle with o_done and must be captured
// then, since the block cannot be stalled. Plot, pixel read and byte read
// go through one read of the store, then the modify and write-back, and no
// new request is taken until that is done. A fill with value 0 or 1 sweeps
// the store one byte per cycle and strobes o_done at the end of the sweep; a
// fill with any other value answers in the cycle after accept. After reset
// o_busy stays high while the store is cleared one byte per cycle.
module page_framebuffer_pixel_engine_unit #(
    parameter int SCREEN_WIDTH  = pfpe_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfpe_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_column,
    input  logic [7:0] i_row,
    input  logic [2:0] i_mode,
    output logic       o_done,
    output logic       o_pixel_value,
    output logic [7:0] o_byte_value
);
    import pfpe_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MOD   = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    // wide enough for the page product and never narrower than a store address
    localparam int SUM_W  = 5 + $clog2(SCREEN_WIDTH) + 1;
    localparam int FULL_W = (SUM_W > ADDR_W) ? SUM_W : ADDR_W;
    localparam logic [8:0]        WIDTH_L  = 9'(SCREEN_WIDTH);
    localparam logic [8:0]        HEIGHT_L = 9'(SCREEN_HEIGHT);
    localparam logic [FULL_W:0]   DEPTH_L  = (FULL_W + 1)'(STORE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(STORE_DEPTH - 1);

    logic [1:0]        r_state;
    logic [ADDR_W-1:0] r_sweep;
    logic              r_fill_val;
    logic              r_fill_req;
    logic [1:0]        r_kind;
    logic [2:0]        r_mode;
    logic [2:0]        r_bit;
    logic [ADDR_W-1:0] r_addr;
    logic              r_hit;
    logic              r_done;
    logic              r_pixel;
    logic [7:0]        r_byte;

    logic              accept;
    logic [FULL_W-1:0] full_addr;
    logic              hit;
    logic [7:0]        rd_data;
    logic [7:0]        mask;
    logic [7:0]        mod_byte;
    t_store_wr         wr;

    assign accept    = i_start && (r_state == S_IDLE);
    assign full_addr = FULL_W'(i_row[7:3]) * FULL_W'(SCREEN_WIDTH) + FULL_W'(i_column);
    assign hit       = ({1'b0, i_column} < WIDTH_L) && ({1'b0, i_row} < HEIGHT_L)
                    && ({1'b0, full_addr} < DEPTH_L);

    assign mask = 8'd1 << r_bit;

    always_comb begin
        if (r_mode inside {PLOT_CLEAR, PLOT_CLEAR_ALT}) begin
            mod_byte = rd_data & ~mask;
        end else if (r_mode == PLOT_INVERT) begin
            mod_byte = rd_data ^ mask;
        end else begin
            mod_byte = rd_data | mask;
        end
    end

    always_comb begin
        wr.en   = 1'b0;
        wr.addr = r_addr;
        wr.data = mod_byte;
        if (r_state == S_SWEEP) begin
            wr.en   = 1'b1;
            wr.addr = r_sweep;
            wr.data = {8{r_fill_val}};
        end else if (r_state == S_MOD) begin
            wr.en = (r_kind == KIND_PLOT) && r_hit;
        end
    end

    pfpe_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (accept),
        .i_rd_addr (full_addr[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_sweep    <= '0;
            r_fill_val <= 1'b0;
            r_fill_req <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= i_kind;
                        r_mode <= i_mode;
                        r_bit  <= i_row[2:0];
                        r_addr <= full_addr[ADDR_W-1:0];
                        r_hit  <= hit;
                        if (i_kind == KIND_FILL) begin
                            if (i_mode inside {FILL_CLEAR, FILL_SET}) begin
                                r_state    <= S_SWEEP;
                                r_sweep    <= '0;
                                r_fill_val <= (i_mode == FILL_SET);
                                r_fill_req <= 1'b1;
                            end else begin
                                // no store change: answer at once
                                r_done  <= 1'b1;
                                r_pixel <= 1'b0;
                                r_byte  <= 8'd0;
                            end
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    r_pixel <= (r_kind == KIND_READ_PIX) && r_hit && rd_data[r_bit];
                    r_byte  <= ((r_kind == KIND_READ_BYTE) && r_hit) ? rd_data : 8'd0;
                end
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == LAST_A) begin
                        r_state    <= S_IDLE;
                        r_fill_req <= 1'b0;
                        // the clearing pass after reset reports nothing
                        r_done     <= r_fill_req;
                        r_pixel    <= 1'b0;
                        r_byte     <= 8'd0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_pixel_value = r_pixel;
    assign o_byte_value  = r_byte;

endmodule

>>> hw/rtl/pfpe_store.sv
module pfpe_store (
    input  logic                       i_clk,
    input  pfpe_pkg::t_store_wr        i_wr,
    input  logic                       i_rd_en,
    input  logic [pfpe_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                 o_rd_data
);
    import pfpe_pkg::*;

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
